// ===== rtl/collision_brake_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the brake sequencer RTL
// Checks are clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COLLISION_BRAKE_SEQUENCER_CORE_MACROS_SVH
`define COLLISION_BRAKE_SEQUENCER_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define CBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define CBS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, codes and reset constants of the brake sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbs_pkg;

    localparam int DISTANCE_BITS_DEF = 10;
    localparam int TIMER_BITS_DEF    = 16;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int HYST_BITS         = 8;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DANGER_DIST  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WARNING_DIST = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HYSTERESIS   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ACTUATION    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RELEASE_HOLD = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EMERG_HOLD   = 3'd6;

    // register reset values
    localparam int RST_DANGER_DIST  = 20;
    localparam int RST_WARNING_DIST = 50;
    localparam int RST_HYSTERESIS   = 5;
    localparam int RST_DEBOUNCE     = 200;
    localparam int RST_ACTUATION    = 500;
    localparam int RST_RELEASE_HOLD = 1000;
    localparam int RST_EMERG_HOLD   = 2000;

    // request opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_PULSE  = 2'd2;

    // alert levels
    localparam logic [1:0] LV_SAFE      = 2'd0;
    localparam logic [1:0] LV_WARNING   = 2'd1;
    localparam logic [1:0] LV_DANGER    = 2'd2;
    localparam logic [1:0] LV_EMERGENCY = 2'd3;

    // servo commands
    localparam logic [1:0] SERVO_HALT     = 2'd0;
    localparam logic [1:0] SERVO_FORWARD  = 2'd1;
    localparam logic [1:0] SERVO_BACKWARD = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_ENGAGE   = 5'b00010,
        PH_RELEASE  = 5'b00100,
        PH_EHOLD    = 5'b01000,
        PH_ERELEASE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0] alert_level;
        logic [1:0] servo_command;
        logic       brake_engaged;
        logic       level_changed;
        logic       busy_res;
    } res_t;

endpackage

// ===== rtl/collision_brake_sequencer_core.sv =====
// An accepted request has its result registered in the result buffer at the accepting edge.
// Throughput: one request per cycle while the skid entry is empty; the two-entry result
//   buffer keeps in_ready high while one result waits; in_ready depends only on buffer state.
// Reset (rst_n low, asynchronous): level safe, brake released, phase idle, timers zero,
//   configuration registers at their default values, result buffer empty.
// ----------------------------------------------------------------------------
// collision_brake_sequencer_core
// Alert level tracking with hysteresis and brake servo sequencing driven by
// millisecond ticks, distance samples and debounced emergency pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module collision_brake_sequencer_core #(
    parameter int DISTANCE_BITS = cbs_pkg::DISTANCE_BITS_DEF,
    parameter int TIMER_BITS    = cbs_pkg::TIMER_BITS_DEF,
    parameter int CFG_BITS      = (TIMER_BITS > DISTANCE_BITS) ? TIMER_BITS : DISTANCE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [cbs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]               cfg_wdata,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [DISTANCE_BITS-1:0]          distance_cm,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        alert_level,
    output logic [1:0]                        servo_command,
    output logic                              brake_engaged,
    output logic                              level_changed,
    output logic                              busy_res
);
    import cbs_pkg::*;

    logic [DISTANCE_BITS-1:0] danger_distance;
    logic [DISTANCE_BITS-1:0] warning_distance;
    logic [HYST_BITS-1:0]     hysteresis_margin;
    logic [TIMER_BITS-1:0]    debounce_ms;
    logic [TIMER_BITS-1:0]    actuation_ms;
    logic [TIMER_BITS-1:0]    release_hold_ms;
    logic [TIMER_BITS-1:0]    emergency_hold_ms;

    logic step;
    res_t step_res;
    res_t out_res;

    // a request is taken whenever the result buffer has a free slot
    assign step = in_valid && in_ready;

    cbs_cfg_regs #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .TIMER_BITS    (TIMER_BITS),
        .CFG_BITS      (CFG_BITS)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wen           (cfg_wen),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .danger_distance   (danger_distance),
        .warning_distance  (warning_distance),
        .hysteresis_margin (hysteresis_margin),
        .debounce_ms       (debounce_ms),
        .actuation_ms      (actuation_ms),
        .release_hold_ms   (release_hold_ms),
        .emergency_hold_ms (emergency_hold_ms)
    );

    // state update and result computed in the same cycle as the request
    cbs_ctrl #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .opcode            (opcode),
        .distance_cm       (distance_cm),
        .danger_distance   (danger_distance),
        .warning_distance  (warning_distance),
        .hysteresis_margin (hysteresis_margin),
        .debounce_ms       (debounce_ms),
        .actuation_ms      (actuation_ms),
        .release_hold_ms   (release_hold_ms),
        .emergency_hold_ms (emergency_hold_ms),
        .res               (step_res)
    );

    // result register plus skid entry
    cbs_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_res),
        .can_push  (in_ready),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (out_res)
    );

    assign alert_level   = out_res.alert_level;
    assign servo_command = out_res.servo_command;
    assign brake_engaged = out_res.brake_engaged;
    assign level_changed = out_res.level_changed;
    assign busy_res      = out_res.busy_res;

endmodule

// ===== rtl/cbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cbs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbs_cfg_regs #(
    parameter int DISTANCE_BITS = cbs_pkg::DISTANCE_BITS_DEF,
    parameter int TIMER_BITS    = cbs_pkg::TIMER_BITS_DEF,
    parameter int CFG_BITS      = (TIMER_BITS > DISTANCE_BITS) ? TIMER_BITS : DISTANCE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [cbs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]              cfg_wdata,
    output logic [DISTANCE_BITS-1:0]         danger_distance,
    output logic [DISTANCE_BITS-1:0]         warning_distance,
    output logic [cbs_pkg::HYST_BITS-1:0]    hysteresis_margin,
    output logic [TIMER_BITS-1:0]            debounce_ms,
    output logic [TIMER_BITS-1:0]            actuation_ms,
    output logic [TIMER_BITS-1:0]            release_hold_ms,
    output logic [TIMER_BITS-1:0]            emergency_hold_ms
);
    import cbs_pkg::*;

    logic [DISTANCE_BITS-1:0] danger_reg;
    logic [DISTANCE_BITS-1:0] warning_reg;
    logic [HYST_BITS-1:0]     hyst_reg;
    logic [TIMER_BITS-1:0]    debounce_reg;
    logic [TIMER_BITS-1:0]    actuation_reg;
    logic [TIMER_BITS-1:0]    rel_hold_reg;
    logic [TIMER_BITS-1:0]    emerg_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_reg     <= DISTANCE_BITS'(RST_DANGER_DIST);
            warning_reg    <= DISTANCE_BITS'(RST_WARNING_DIST);
            hyst_reg       <= HYST_BITS'(RST_HYSTERESIS);
            debounce_reg   <= TIMER_BITS'(RST_DEBOUNCE);
            actuation_reg  <= TIMER_BITS'(RST_ACTUATION);
            rel_hold_reg   <= TIMER_BITS'(RST_RELEASE_HOLD);
            emerg_hold_reg <= TIMER_BITS'(RST_EMERG_HOLD);
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_DANGER_DIST:  danger_reg     <= cfg_wdata[DISTANCE_BITS-1:0];
                CFG_WARNING_DIST: warning_reg    <= cfg_wdata[DISTANCE_BITS-1:0];
                CFG_HYSTERESIS:   hyst_reg       <= cfg_wdata[HYST_BITS-1:0];
                CFG_DEBOUNCE:     debounce_reg   <= cfg_wdata[TIMER_BITS-1:0];
                CFG_ACTUATION:    actuation_reg  <= cfg_wdata[TIMER_BITS-1:0];
                CFG_RELEASE_HOLD: rel_hold_reg   <= cfg_wdata[TIMER_BITS-1:0];
                CFG_EMERG_HOLD:   emerg_hold_reg <= cfg_wdata[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign danger_distance   = danger_reg;
    assign warning_distance  = warning_reg;
    assign hysteresis_margin = hyst_reg;
    assign debounce_ms       = debounce_reg;
    assign actuation_ms      = actuation_reg;
    assign release_hold_ms   = rel_hold_reg;
    assign emergency_hold_ms = emerg_hold_reg;

endmodule

// ===== rtl/cbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbs_ctrl
// Alert level, brake phase and timer state; one request per cycle while step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "collision_brake_sequencer_core_macros.svh"

module cbs_ctrl #(
    parameter int DISTANCE_BITS = cbs_pkg::DISTANCE_BITS_DEF,
    parameter int TIMER_BITS    = cbs_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [1:0]                    opcode,
    input  logic [DISTANCE_BITS-1:0]      distance_cm,
    input  logic [DISTANCE_BITS-1:0]      danger_distance,
    input  logic [DISTANCE_BITS-1:0]      warning_distance,
    input  logic [cbs_pkg::HYST_BITS-1:0] hysteresis_margin,
    input  logic [TIMER_BITS-1:0]         debounce_ms,
    input  logic [TIMER_BITS-1:0]         actuation_ms,
    input  logic [TIMER_BITS-1:0]         release_hold_ms,
    input  logic [TIMER_BITS-1:0]         emergency_hold_ms,
    output cbs_pkg::res_t                 res
);
    import cbs_pkg::*;

    localparam int SUM_BITS = DISTANCE_BITS + 1;

    logic [1:0]            level_reg, level_next;
    logic                  brake_reg, brake_next;
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic [TIMER_BITS-1:0] since_act_reg, since_act_next;
    logic [TIMER_BITS-1:0] since_em_reg, since_em_next;
    logic                  latch_reg, latch_next;

    logic [SUM_BITS-1:0]   up_safe;
    logic [SUM_BITS-1:0]   up_warn;
    logic [SUM_BITS-1:0]   dist_ext;
    logic                  idle_now;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        sat_inc = (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
    endfunction

    assign up_safe  = SUM_BITS'(warning_distance) + SUM_BITS'(hysteresis_margin);
    assign up_warn  = SUM_BITS'(danger_distance) + SUM_BITS'(hysteresis_margin);
    assign dist_ext = SUM_BITS'(distance_cm);
    assign idle_now = (phase_reg == PH_IDLE);

    always_comb
    begin
        level_next     = level_reg;
        brake_next     = brake_reg;
        phase_next     = phase_reg;
        ptimer_next    = ptimer_reg;
        since_act_next = since_act_reg;
        since_em_next  = since_em_reg;
        latch_next     = latch_reg;

        case (opcode)
            OP_TICK:
            begin
                since_act_next = sat_inc(since_act_reg);
                since_em_next  = sat_inc(since_em_reg);
                if (phase_reg != PH_IDLE)
                begin
                    ptimer_next = sat_inc(ptimer_reg);
                    case (phase_reg)
                        PH_ENGAGE, PH_RELEASE:
                        begin
                            if (ptimer_next >= actuation_ms)
                            begin
                                brake_next     = (phase_reg == PH_ENGAGE);
                                since_act_next = '0;
                                phase_next     = PH_IDLE;
                                ptimer_next    = '0;
                            end
                        end
                        PH_EHOLD:
                        begin
                            if (ptimer_next >= emergency_hold_ms)
                            begin
                                level_next  = LV_SAFE;
                                phase_next  = PH_ERELEASE;
                                ptimer_next = '0;
                            end
                        end
                        default:
                        begin
                            if (ptimer_next >= actuation_ms)
                            begin
                                brake_next     = 1'b0;
                                since_act_next = '0;
                                latch_next     = 1'b0;
                                phase_next     = PH_IDLE;
                                ptimer_next    = '0;
                            end
                        end
                    endcase
                end
            end
            OP_SAMPLE:
            begin
                // samples are dropped while any phase runs
                if (phase_reg == PH_IDLE)
                begin
                    case (level_reg)
                        LV_SAFE:
                        begin
                            if (distance_cm <= danger_distance)
                                level_next = LV_DANGER;
                            else if (distance_cm <= warning_distance)
                                level_next = LV_WARNING;
                        end
                        LV_WARNING:
                        begin
                            if (distance_cm <= danger_distance)
                                level_next = LV_DANGER;
                            else if (dist_ext > up_safe)
                                level_next = LV_SAFE;
                        end
                        LV_DANGER:
                        begin
                            if (dist_ext > up_safe)
                                level_next = LV_SAFE;
                            else if (dist_ext > up_warn)
                                level_next = LV_WARNING;
                        end
                        default: ;
                    endcase
                end
            end
            OP_PULSE:
            begin
                if (since_em_reg > debounce_ms)
                begin
                    since_em_next = '0;
                    if (phase_reg != PH_IDLE)
                        latch_next = 1'b1;
                    else
                        level_next = LV_EMERGENCY;
                end
            end
            default: ;
        endcase

        // settle: in idle, raise a latched pulse to emergency and start the action the level calls for
        if (phase_next == PH_IDLE)
        begin
            if (latch_next)
            begin
                latch_next = 1'b0;
                level_next = LV_EMERGENCY;
            end
            if ((level_next inside {LV_DANGER, LV_EMERGENCY}) && !brake_next)
            begin
                phase_next  = PH_ENGAGE;
                ptimer_next = '0;
            end
            else if (level_next == LV_EMERGENCY)
            begin
                phase_next  = PH_EHOLD;
                ptimer_next = '0;
            end
            else if ((level_next inside {LV_SAFE, LV_WARNING}) && brake_next
                     && (since_act_next >= release_hold_ms))
            begin
                phase_next  = PH_RELEASE;
                ptimer_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LV_SAFE;
            brake_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            ptimer_reg    <= '0;
            since_act_reg <= '0;
            since_em_reg  <= '0;
            latch_reg     <= 1'b0;
        end
        else if (step)
        begin
            level_reg     <= level_next;
            brake_reg     <= brake_next;
            phase_reg     <= phase_next;
            ptimer_reg    <= ptimer_next;
            since_act_reg <= since_act_next;
            since_em_reg  <= since_em_next;
            latch_reg     <= latch_next;
        end
    end

    // previous result level is always the stored level
    always_comb
    begin
        res.alert_level   = level_next;
        case (phase_next)
            PH_ENGAGE:               res.servo_command = SERVO_FORWARD;
            PH_RELEASE, PH_ERELEASE: res.servo_command = SERVO_BACKWARD;
            default:                 res.servo_command = SERVO_HALT;
        endcase
        res.brake_engaged = brake_next;
        res.level_changed = (level_next != level_reg);
        res.busy_res      = (phase_next != PH_IDLE);
    end

    `CBS_ASSERT(a_engage_brake_off, (phase_reg == PH_ENGAGE) |-> !brake_reg, "engage, brake on")
    `CBS_ASSERT(a_ehold_level, (phase_reg == PH_EHOLD) |-> level_reg == LV_EMERGENCY, "bad hold")
    `CBS_ASSERT(a_erelease_safe, (phase_reg == PH_ERELEASE) |-> level_reg == LV_SAFE, "not safe")
    `CBS_ASSERT(a_idle_level, idle_now |-> level_reg != LV_EMERGENCY, "emergency left in idle")
    `CBS_ASSERT(a_idle_latch, idle_now |-> !latch_reg, "latch left in idle")
    `CBS_ASSERT(a_danger_brake, idle_now && level_reg == LV_DANGER |-> brake_reg, "no brake")

endmodule

// ===== rtl/cbs_out_buf.sv =====
// ----------------------------------------------------------------------------
// cbs_out_buf
// Two-entry result buffer; input ready comes from a register only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "collision_brake_sequencer_core_macros.svh"

module cbs_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbs_pkg::res_t push_data,
    output logic          can_push,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cbs_pkg::res_t pop_data
);
    import cbs_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = main_valid_reg && pop_ready;
    assign can_push  = !skid_valid_reg;
    assign pop_valid = main_valid_reg;
    assign pop_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (main_valid_reg && !pop)
        begin
            skid_valid_reg <= push;
        end
        else
        begin
            main_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (main_valid_reg && !pop)
        begin
            if (push)
                skid_reg <= push_data;
        end
        else if (push)
        begin
            main_reg <= push_data;
        end
    end

    `CBS_ASSERT(a_skid_needs_main, skid_valid_reg |-> main_valid_reg, "skid without head")
    `CBS_ASSERT_NEXT(a_skid_drains, skid_valid_reg && pop, !skid_valid_reg, "skid stuck")
    `CBS_ASSERT(a_push_room, push |-> can_push, "push while full")

endmodule

// ===== test/tb_collision_brake_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_collision_brake_sequencer_core
// Self-checking bench for the brake sequencer: short directed sequences,
// then randomized ticks, samples and pulses under several register settings,
// with random stalls on both channels and every result checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_collision_brake_sequencer_core;

    import cbs_pkg::*;

    localparam int DW = DISTANCE_BITS_DEF;
    localparam int TW = TIMER_BITS_DEF;
    localparam int CW = (TW > DW) ? TW : DW;

    // opcode with no function; the block must still answer it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [TW-1:0] TIMER_TOP   = '1;
    localparam int            CYCLE_LIMIT = 400000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the sequencer state and queues the status words
    // that the block must return, one per accepted request.
    // ------------------------------------------------------------------------
    class brake_tracker;
        // register copies
        logic [DW-1:0]        danger_dist, warning_dist;
        logic [HYST_BITS-1:0] hyst;
        logic [TW-1:0]        debounce, actuation, release_hold, emerg_hold;
        // sequencer state
        logic [1:0]    level, prev_level;
        logic          brake_on, emerg_latched;
        phase_t        phase;
        logic [TW-1:0] phase_timer, since_act, since_emerg;

        res_t expected_status_q[$];
        int   errors, requests_noted, results_checked;

        function new();
            danger_dist    = DW'(RST_DANGER_DIST);
            warning_dist   = DW'(RST_WARNING_DIST);
            hyst           = HYST_BITS'(RST_HYSTERESIS);
            debounce       = TW'(RST_DEBOUNCE);
            actuation      = TW'(RST_ACTUATION);
            release_hold   = TW'(RST_RELEASE_HOLD);
            emerg_hold     = TW'(RST_EMERG_HOLD);
            level          = LV_SAFE;
            prev_level     = LV_SAFE;
            brake_on       = 1'b0;
            emerg_latched  = 1'b0;
            phase          = PH_IDLE;
            phase_timer    = '0;
            since_act      = '0;
            since_emerg    = '0;
            errors          = 0;
            requests_noted  = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CW-1:0] val);
            case (idx)
                CFG_DANGER_DIST:  danger_dist  = val[DW-1:0];
                CFG_WARNING_DIST: warning_dist = val[DW-1:0];
                CFG_HYSTERESIS:   hyst         = val[HYST_BITS-1:0];
                CFG_DEBOUNCE:     debounce     = val[TW-1:0];
                CFG_ACTUATION:    actuation    = val[TW-1:0];
                CFG_RELEASE_HOLD: release_hold = val[TW-1:0];
                CFG_EMERG_HOLD:   emerg_hold   = val[TW-1:0];
                default: ;
            endcase
        endfunction

        function logic [TW-1:0] bump(logic [TW-1:0] t);
            return (t == TIMER_TOP) ? t : t + 1'b1;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // Advance the mirrored state by one request and queue its status.
        function void note_request(logic [1:0] op, logic [DW-1:0] dist_cm);
            int   up_safe, up_warn;
            res_t want;
            up_safe = int'(warning_dist) + int'(hyst);
            up_warn = int'(danger_dist) + int'(hyst);
            requests_noted++;

            case (op)
                OP_TICK: begin
                    since_act   = bump(since_act);
                    since_emerg = bump(since_emerg);
                    if (phase != PH_IDLE) begin
                        phase_timer = bump(phase_timer);
                        case (phase)
                            PH_ENGAGE, PH_RELEASE: begin
                                if (phase_timer >= actuation) begin
                                    brake_on    = (phase == PH_ENGAGE);
                                    since_act   = '0;
                                    phase       = PH_IDLE;
                                    phase_timer = '0;
                                end
                            end
                            PH_EHOLD: begin
                                if (phase_timer >= emerg_hold) begin
                                    level       = LV_SAFE;
                                    phase       = PH_ERELEASE;
                                    phase_timer = '0;
                                end
                            end
                            default: begin
                                // emergency release also drops pulses latched meanwhile
                                if (phase_timer >= actuation) begin
                                    brake_on      = 1'b0;
                                    since_act     = '0;
                                    emerg_latched = 1'b0;
                                    phase         = PH_IDLE;
                                    phase_timer   = '0;
                                end
                            end
                        endcase
                    end
                end
                OP_SAMPLE: begin
                    // samples are dropped unless idle
                    if (phase == PH_IDLE) begin
                        if (level == LV_SAFE) begin
                            if (dist_cm <= danger_dist)       level = LV_DANGER;
                            else if (dist_cm <= warning_dist) level = LV_WARNING;
                        end else if (level == LV_WARNING) begin
                            if (dist_cm <= danger_dist)       level = LV_DANGER;
                            else if (int'(dist_cm) > up_safe) level = LV_SAFE;
                        end else if (level == LV_DANGER) begin
                            if (int'(dist_cm) > up_safe)      level = LV_SAFE;
                            else if (int'(dist_cm) > up_warn) level = LV_WARNING;
                        end
                    end
                end
                OP_PULSE: begin
                    if (since_emerg > debounce) begin
                        since_emerg = '0;
                        if (phase != PH_IDLE) emerg_latched = 1'b1;
                        else                  level = LV_EMERGENCY;
                    end
                end
                default: ;
            endcase

            // from idle, launch whatever the level now calls for
            if (phase == PH_IDLE) begin
                if (emerg_latched) begin
                    emerg_latched = 1'b0;
                    level         = LV_EMERGENCY;
                end
                if (level >= LV_DANGER && !brake_on) begin
                    phase       = PH_ENGAGE;
                    phase_timer = '0;
                end else if (level == LV_EMERGENCY) begin
                    phase       = PH_EHOLD;
                    phase_timer = '0;
                end else if (level < LV_DANGER && brake_on && since_act >= release_hold) begin
                    phase       = PH_RELEASE;
                    phase_timer = '0;
                end
            end

            want.alert_level   = level;
            want.servo_command = (phase == PH_ENGAGE) ? SERVO_FORWARD :
                                 (phase == PH_RELEASE || phase == PH_ERELEASE) ?
                                 SERVO_BACKWARD : SERVO_HALT;
            want.brake_engaged = brake_on;
            want.level_changed = (level != prev_level);
            want.busy_res      = (phase != PH_IDLE);
            prev_level = level;
            expected_status_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(res_t got);
            res_t want;
            if (expected_status_q.size() == 0) begin
                $error("status returned with no request outstanding");
                errors++;
                return;
            end
            want = expected_status_q.pop_front();
            results_checked++;
            compare_field("alert_level", want.alert_level, got.alert_level);
            compare_field("servo_command", want.servo_command, got.servo_command);
            compare_field("brake_engaged", 2'(want.brake_engaged), 2'(got.brake_engaged));
            compare_field("level_changed", 2'(want.level_changed), 2'(got.level_changed));
            compare_field("busy_res", 2'(want.busy_res), 2'(got.busy_res));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wen     = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr    = '0;
    logic [CW-1:0]            cfg_wdata   = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [1:0]               opcode      = OP_TICK;
    logic [DW-1:0]            distance_cm = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [1:0]               alert_level;
    logic [1:0]               servo_command;
    logic                     brake_engaged;
    logic                     level_changed;
    logic                     busy_res;

    brake_tracker tracker;
    int           cycle_count    = 0;
    int           settings_count = 1;   // reset defaults count as the first setting
    bit           allow_idle     = 1'b1;
    bit           idle_on        = 1'b1;

    collision_brake_sequencer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .distance_cm   (distance_cm),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .alert_level   (alert_level),
        .servo_command (servo_command),
        .brake_engaged (brake_engaged),
        .level_changed (level_changed),
        .busy_res      (busy_res)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d status words outstanding",
                     cycle_count, tracker.pending());
            $display("tb_collision_brake_sequencer_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check at the rising edge, choose out_ready at the falling
    // edge. Stalls come in random bursts while idling is enabled.
    // ------------------------------------------------------------------------
    initial
    begin : status_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_status({alert_level, servo_command, brake_engaged,
                                      level_changed, busy_res});
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 10) begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [1:0] op, input logic [DW-1:0] dist_cm);
        in_valid    <= 1'b1;
        opcode      <= op;
        distance_cm <= dist_cm;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_request(op, dist_cm);
        @(negedge clk);
    endtask

    // Drop valid and wait until every status word has come back.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        // spare wait before touching registers
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CW-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        tracker.write_reg(idx, val);
        @(negedge clk);
    endtask

    // Write all seven registers back to back, then release the write enable.
    task automatic program_regs(input int dd, input int wd, input int hy, input int db,
                                input int ac, input int rh, input int eh);
        write_reg(CFG_DANGER_DIST, CW'(dd));
        write_reg(CFG_WARNING_DIST, CW'(wd));
        write_reg(CFG_HYSTERESIS, CW'(hy));
        write_reg(CFG_DEBOUNCE, CW'(db));
        write_reg(CFG_ACTUATION, CW'(ac));
        write_reg(CFG_RELEASE_HOLD, CW'(rh));
        write_reg(CFG_EMERG_HOLD, CW'(eh));
        cfg_wen <= 1'b0;
        @(negedge clk);
        settings_count++;
    endtask

    // Short timers so that engage, hold, release and emergency cycles all
    // complete many times within a few hundred requests.
    task automatic program_short_timers();
        int dd;
        dd = $urandom_range(0, 150);
        program_regs(dd, dd + $urandom_range(0, 300), $urandom_range(0, 40),
                     $urandom_range(0, 20), $urandom_range(1, 6),
                     $urandom_range(0, 12), $urandom_range(0, 15));
    endtask

    // Distances cluster around the active thresholds, with full-range noise.
    function automatic logic [DW-1:0] pick_distance();
        int base, d;
        case ($urandom_range(0, 5))
            0:       base = int'(tracker.danger_dist);
            1:       base = int'(tracker.warning_dist);
            2:       base = int'(tracker.danger_dist) + int'(tracker.hyst);
            3:       base = int'(tracker.warning_dist) + int'(tracker.hyst);
            4:       base = $urandom_range(0, (1 << DW) - 1);
            default: base = $urandom_range(0, 1) ? 0 : (1 << DW) - 1;
        endcase
        d = base + int'($urandom_range(0, 4)) - 2;
        if (d < 0 || d > (1 << DW) - 1)
            d = $urandom_range(0, (1 << DW) - 1);
        return d[DW-1:0];
    endfunction

    // Random request mix: mostly ticks and samples, some pulses, a few
    // unused opcodes. Every third stretch of 40 requests runs without gaps.
    task automatic run_random(input int count);
        int         r;
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            idle_on = allow_idle && (((i / 40) % 3) != 2);
            if (idle_on && $urandom_range(0, 99) < 8) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 50)      op = OP_TICK;
            else if (r < 80) op = OP_SAMPLE;
            else if (r < 94) op = OP_PULSE;
            else             op = OP_UNUSED;
            send_request(op, (op == OP_SAMPLE) ? pick_distance()
                                               : DW'($urandom_range(0, (1 << DW) - 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        tracker = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: unused opcode, pulse inside debounce window,
        // hysteresis step back to safe, danger engages, busy drops a sample.
        send_request(OP_UNUSED, '0);
        send_request(OP_PULSE, '0);
        send_request(OP_SAMPLE, '1);
        send_request(OP_SAMPLE, 10'd50);
        send_request(OP_SAMPLE, 10'd56);
        send_request(OP_SAMPLE, 10'd20);
        send_request(OP_SAMPLE, '1);
        send_request(OP_TICK, '0);
        wait_quiet();

        // Zero holds and one-tick actuation: engage finishes on the next
        // tick, release starts at once, emergency runs its full cycle and a
        // pulse taken during it is discarded at the end of the release.
        program_regs(100, 300, 10, 0, 1, 0, 0);
        send_request(OP_TICK, '0);
        send_request(OP_SAMPLE, 10'd110);
        send_request(OP_SAMPLE, 10'd111);
        send_request(OP_TICK, '0);
        send_request(OP_SAMPLE, 10'd310);
        send_request(OP_SAMPLE, 10'd311);
        send_request(OP_PULSE, '0);
        send_request(OP_PULSE, '0);
        send_request(OP_TICK, '0);
        send_request(OP_PULSE, '0);
        send_request(OP_TICK, '0);
        send_request(OP_TICK, '0);
        send_request(OP_SAMPLE, '0);
        send_request(OP_UNUSED, '1);
        send_request(OP_TICK, '0);
        wait_quiet();

        program_short_timers();
        run_random(250);
        wait_quiet();

        // thresholds at the top: every sample is danger, no step back down
        program_regs((1 << DW) - 1, (1 << DW) - 1, (1 << HYST_BITS) - 1, 0, 1, 0, 0);
        run_random(150);
        wait_quiet();

        program_short_timers();
        run_random(250);
        wait_quiet();

        // thresholds at zero, timers at their maximum: pulses never pass
        // debounce and a phase in progress does not finish within the run
        program_regs(0, 0, 0, int'(TIMER_TOP), int'(TIMER_TOP), int'(TIMER_TOP),
                     int'(TIMER_TOP));
        run_random(100);
        wait_quiet();

        // warning threshold below danger threshold
        program_regs(600, 200, 100, 5, 3, 4, 6);
        run_random(150);
        wait_quiet();

        program_short_timers();
        run_random(250);
        wait_quiet();

        // final stretch at full rate on both channels
        allow_idle = 1'b0;
        program_short_timers();
        run_random(250);
        wait_quiet();
        repeat (10) @(negedge clk);

        $display("coverage: %0d requests sent, %0d status words compared, %0d register settings",
                 tracker.requests_noted, tracker.results_checked, settings_count);
        $display("coverage: defaults, zero and maximum timers, thresholds at both ends");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_collision_brake_sequencer_core: clean");
        end else begin
            $display("tb_collision_brake_sequencer_core: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_cfg_regs.sv
rtl/cbs_ctrl.sv
rtl/cbs_out_buf.sv
rtl/collision_brake_sequencer_core.sv
test/tb_collision_brake_sequencer_core.sv
